// ===== hdl/cpa_pkg.sv =====
package cpa_pkg;

  // Field widths of one transaction
  localparam int unsigned FuncW   = 1;
  localparam int unsigned WantW   = 6;
  localparam int unsigned ChanW   = 5;
  localparam int unsigned StatusW = 2;

  // Largest run of grants one get may produce
  localparam logic [WantW-1:0] MaxResults = 6'd32;

  // Operation codes carried on the input tuser
  localparam logic [FuncW-1:0] FuncGet  = 1'b0;
  localparam logic [FuncW-1:0] FuncFree = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk          = 2'd0;
  localparam logic [StatusW-1:0] StatusNoChannel   = 2'd1;
  localparam logic [StatusW-1:0] StatusAlreadyFree = 2'd2;

  // Update request toward the busy map
  typedef struct packed {
    logic set;  // mark the addressed channel busy
    logic clr;  // mark the addressed channel free
  } map_cmd_t;

endpackage

// ===== hdl/cpa_map.sv =====
module cpa_map #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned POOL_SIZE    = 10,
  parameter int unsigned IDX_W        = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IDX_W-1:0]   idx_i,
  input  cpa_pkg::map_cmd_t  cmd_i,
  output logic               busy_o
);

  localparam int unsigned PoolEff  = (POOL_SIZE > NUM_CHANNELS) ? NUM_CHANNELS : POOL_SIZE;
  localparam int unsigned FreeBase = NUM_CHANNELS - PoolEff;

  logic [NUM_CHANNELS-1:0] map_q;

  // Channels below the free pool come out of reset busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        map_q[i] <= (i < int'(FreeBase)) ? 1'b1 : 1'b0;
      end
    end else if (cmd_i.set) begin
      map_q[idx_i] <= 1'b1;
    end else if (cmd_i.clr) begin
      map_q[idx_i] <= 1'b0;
    end
  end

  assign busy_o = map_q[idx_i];

endmodule

// ===== hdl/channel_pool_allocator.sv =====
// Channel      Dir  tdata bits (low first)                tuser          tlast
// s_axis       in   want_count[5:0], free_channel[10:6]   func           -
// m_axis       out  granted_channel[4:0], status[6:5]     has_channel    last
//
// One transaction at a time. A free goes to StFinal, which clears the
// map bit and registers the result. A get walks the busy map with one shared
// bit-test/count unit: it first counts the free channels over the whole map,
// then scans down for grants, one result per free channel found.
// Reset loads the map at once: channels below the top POOL_SIZE are busy.
// A stalled m_axis holds the scan at the next result; s_axis is ready only
// while the sequencer is idle.
module channel_pool_allocator #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned POOL_SIZE    = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // want_count[5:0], free_channel[10:6], zero
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // granted_channel[4:0], status[6:5], zero
  output logic        m_axis_tuser,   // has_channel
  output logic        m_axis_tlast    // last
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned CmpW = (CntW > cpa_pkg::WantW) ? CntW : cpa_pkg::WantW;
  localparam logic [IdxW-1:0] TopIdx = IdxW'(NUM_CHANNELS - 1);

  // Sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCount = 2'd1;
  localparam logic [1:0] StGrant = 2'd2;
  localparam logic [1:0] StFinal = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [cpa_pkg::WantW-1:0]    left_q, left_d;
  logic                         fail_q, fail_d;
  logic [cpa_pkg::FuncW-1:0]    func_q;
  logic [cpa_pkg::WantW-1:0]    want_q;
  logic [cpa_pkg::ChanW-1:0]    fch_q;

  logic                         out_valid_q, out_valid_d;
  logic [cpa_pkg::ChanW-1:0]    out_chan_q, out_chan_d;
  logic                         out_has_q, out_has_d;
  logic [cpa_pkg::StatusW-1:0]  out_status_q, out_status_d;
  logic                         out_last_q, out_last_d;

  logic                         in_fire;
  logic                         slot_free;
  logic                         emit;
  logic [IdxW-1:0]              map_idx;
  cpa_pkg::map_cmd_t            map_cmd;
  logic                         map_busy;
  logic [CntW-1:0]              total;
  logic                         fch_valid;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign total         = cnt_q + CntW'(!map_busy);
  assign fch_valid     = (32'(fch_q) < NUM_CHANNELS);

  // Shared bit-test unit: the freed channel in StFinal, the scan index in every other state
  assign map_idx = (state_q == StFinal) ? IdxW'(fch_q) : idx_q;

  cpa_map #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .POOL_SIZE    (POOL_SIZE),
    .IDX_W        (IdxW)
  ) u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (map_idx),
    .cmd_i  (map_cmd),
    .busy_o (map_busy)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    left_d       = left_q;
    fail_d       = fail_q;
    map_cmd      = '0;
    emit         = 1'b0;
    out_chan_d   = out_chan_q;
    out_has_d    = out_has_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          idx_d  = TopIdx;
          cnt_d  = '0;
          fail_d = 1'b0;
          // Zero-channel gets and frees answer at once
          if (s_axis_tuser == cpa_pkg::FuncGet && s_axis_tdata[5:0] != '0) begin
            state_d = StCount;
          end else begin
            state_d = StFinal;
          end
        end
      end
      StCount: begin
        // Tally one map bit a cycle, top down
        cnt_d = total;
        idx_d = idx_q - IdxW'(1);
        if (idx_q == '0) begin
          idx_d  = TopIdx;
          left_d = want_q;
          if (want_q > cpa_pkg::MaxResults || CmpW'(want_q) > CmpW'(total)) begin
            fail_d  = 1'b1;
            state_d = StFinal;
          end else begin
            state_d = StGrant;
          end
        end
      end
      StGrant: begin
        if (map_busy) begin
          idx_d = idx_q - IdxW'(1);
        end else if (slot_free) begin
          // Claim this channel and hand it out
          map_cmd.set  = 1'b1;
          emit         = 1'b1;
          out_chan_d   = cpa_pkg::ChanW'(idx_q);
          out_has_d    = 1'b1;
          out_status_d = cpa_pkg::StatusOk;
          out_last_d   = (left_q == cpa_pkg::WantW'(1));
          left_d       = left_q - cpa_pkg::WantW'(1);
          idx_d        = idx_q - IdxW'(1);
          if (left_q == cpa_pkg::WantW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      StFinal: begin
        if (slot_free) begin
          emit       = 1'b1;
          out_chan_d = '0;
          out_has_d  = 1'b0;
          out_last_d = 1'b1;
          if (func_q == cpa_pkg::FuncFree) begin
            if (fch_valid && map_busy) begin
              map_cmd.clr  = 1'b1;
              out_status_d = cpa_pkg::StatusOk;
            end else begin
              out_status_d = cpa_pkg::StatusAlreadyFree;
            end
          end else begin
            out_status_d = fail_q ? cpa_pkg::StatusNoChannel : cpa_pkg::StatusOk;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: load on emit, drop once taken
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      fail_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      fail_q      <= fail_d;
    end
  end

  // Hold the request fields for the whole transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= s_axis_tuser;
      want_q <= s_axis_tdata[5:0];
      fch_q  <= s_axis_tdata[10:6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_chan_q   <= out_chan_d;
      out_has_q    <= out_has_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_status_q, out_chan_q};
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_last_q;

endmodule
